// ===== sv/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-frame ring allocator package
// Field widths, register indexes, item kinds and the types shared by the
// allocator top level and its step datapath.
// ----------------------------------------------------------------------------
package pra_pkg;

  // Field widths of the stream beats and configuration registers.
  localparam int KIND_W   = 2;
  localparam int REQ_W    = 25;
  localparam int ALIGN_W  = 4;
  localparam int ADDR_W   = 32;
  localparam int PAGES_W  = 13;
  localparam int OFF_W    = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  // Page geometry: a slice is counted in 4096-byte pages, at most 4096 pages.
  localparam int PAGE_SHIFT = 12;
  localparam logic [PAGES_W-1:0] MAX_SLICE_PAGES = 13'd4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_READY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_PAGES  = 2'd2;

  // Item kinds carried on in_tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  // Allocator context that does not depend on the frame count.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] peak;
    logic             overflow;
  } ctx_t;

  // One result beat.
  typedef struct packed {
    logic              overflowed;
    logic [OFF_W-1:0]  high_water;
    logic [ADDR_W-1:0] address;
    logic              granted;
  } res_t;

endpackage

// ===== sv/pra_step.sv =====
// ----------------------------------------------------------------------------
// Per-frame ring allocator step datapath
// Combinational update for one item: align, fit check, address forming,
// frame stepping and the high-water mark.
// ----------------------------------------------------------------------------
module pra_step #(
  parameter int FRAMES = 3
) (
  input  logic [pra_pkg::KIND_W-1:0]  kind,
  input  logic [pra_pkg::REQ_W-1:0]   request_bytes,
  input  logic [pra_pkg::ALIGN_W-1:0] align_log2,
  input  logic                        ring_ready,
  input  logic [pra_pkg::ADDR_W-1:0]  base_address,
  input  logic [pra_pkg::PAGES_W-1:0] slice_pages,
  input  pra_pkg::ctx_t               ctx,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_idx,
  output pra_pkg::ctx_t               ctx_nxt,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_idx_nxt,
  output pra_pkg::res_t               res
);
  import pra_pkg::*;

  localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int ALN_W   = OFF_W + 1;
  localparam int SUM_W   = OFF_W + 2;
  localparam int FOFF_W  = FIDX_W + PAGES_W;
  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);

  logic [PAGES_W-1:0] pages_sat;
  logic [OFF_W-1:0]   slice_bytes;
  logic [ALN_W-1:0]   align_mask;
  logic [ALN_W-1:0]   aligned;
  logic [SUM_W-1:0]   end_offset;
  logic               fits;
  logic [FOFF_W-1:0]  frame_pages;
  logic [ADDR_W-1:0]  grant_addr;

  // Slice size in bytes, saturated at 4096 pages.
  assign pages_sat   = (slice_pages > MAX_SLICE_PAGES) ? MAX_SLICE_PAGES : slice_pages;
  assign slice_bytes = {pages_sat, {PAGE_SHIFT{1'b0}}};

  // Round the offset up to the alignment and check the request against the slice.
  assign align_mask = (ALN_W'(1) << align_log2) - ALN_W'(1);
  assign aligned    = (ALN_W'(ctx.offset) + align_mask) & ~align_mask;
  assign end_offset = SUM_W'(aligned) + SUM_W'(request_bytes);
  assign fits       = (end_offset <= SUM_W'(slice_bytes));

  // Granted address: base plus the start of this frame's slice plus the offset.
  assign frame_pages = FOFF_W'(frame_idx) * FOFF_W'(pages_sat);
  assign grant_addr  = base_address
                     + ADDR_W'({frame_pages, {PAGE_SHIFT{1'b0}}})
                     + ADDR_W'(aligned);

  // Next context and the result beat.
  always_comb begin
    ctx_nxt        = ctx;
    frame_idx_nxt  = frame_idx;
    res.granted    = 1'b0;
    res.address    = '0;
    case (kind_t'(kind))
      KIND_ALLOC: begin
        if (ring_ready) begin
          if (fits) begin
            ctx_nxt.offset = OFF_W'(end_offset);
            res.granted    = 1'b1;
            res.address    = grant_addr;
          end else begin
            ctx_nxt.overflow = 1'b1;
          end
        end
      end
      KIND_FRAME: begin
        if (ctx.offset > ctx.peak) begin
          ctx_nxt.peak = ctx.offset;
        end
        frame_idx_nxt    = (frame_idx == LAST_FRAME) ? '0 : frame_idx + FIDX_W'(1);
        ctx_nxt.offset   = '0;
        ctx_nxt.overflow = 1'b0;
      end
      KIND_RESTART: begin
        ctx_nxt.offset = '0;
        frame_idx_nxt  = '0;
      end
      default: begin
        // Unused kind: nothing changes.
      end
    endcase
    res.high_water = ctx_nxt.peak;
    res.overflowed = ctx_nxt.overflow;
  end

endmodule

// ===== sv/per_frame_ring_allocator.sv =====
// ----------------------------------------------------------------------------
// Per-frame ring allocator
// Bump allocator over a ring split into FRAMES equal slices, one per frame.
//
//   Channel  Direction  Beat contents (low bits first)
//   in_      slave      tdata: request_bytes, align_log2; tuser: kind
//   out_     master     tdata: granted, address, high_water, overflowed
//   cfg_     write      index 0 ring_ready, 1 base_address, 2 slice_pages
//
// One beat per cycle sustained while out_ is not stalled. Each beat passes
// through the input register, then the result register, to out_.
// The offset update is an align, add and compare loop through the state register.
// Reset (rst_n low, synchronous) clears the allocator state, the configuration
// registers and the valid flags. A stalled output holds its beat; the input
// register keeps taking beats until both stages are full.
// ----------------------------------------------------------------------------
module per_frame_ring_allocator #(
  parameter int FRAMES = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [24:0] request_bytes, [28:25] align_log2, [31:29] zero
  input  logic [pra_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [pra_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] granted, [32:1] address, [57:33] high_water, [58] overflowed, [63:59] zero
  output logic [pra_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pra_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);
  localparam logic [OFF_W-1:0]  MAX_SLICE_BYTES = OFF_W'(1) << (OFF_W - 1);

  // Configuration registers.
  logic               ring_ready_r;
  logic [ADDR_W-1:0]  base_address_r;
  logic [PAGES_W-1:0] slice_pages_r;

  // Input stage.
  logic               in_valid_r;
  logic [KIND_W-1:0]  in_kind_r;
  logic [REQ_W-1:0]   in_req_r;
  logic [ALIGN_W-1:0] in_align_r;

  // Allocator state.
  ctx_t               ctx_r;
  ctx_t               ctx_nxt;
  logic [FIDX_W-1:0]  frame_idx_r;
  logic [FIDX_W-1:0]  frame_idx_nxt;

  // Result stage.
  logic               out_valid_r;
  res_t               out_res_r;
  res_t               res_nxt;

  logic               advance;
  logic               in_take;

  // Handshake: the item in the input register moves on when the result slot frees.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_ready_r   <= 1'b0;
      base_address_r <= '0;
      slice_pages_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RING_READY:   ring_ready_r   <= cfg_wdata[0];
        CFG_BASE_ADDRESS: base_address_r <= cfg_wdata[ADDR_W-1:0];
        CFG_SLICE_PAGES:  slice_pages_r  <= cfg_wdata[PAGES_W-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r  <= in_tuser;
      in_req_r   <= in_tdata[REQ_W-1:0];
      in_align_r <= in_tdata[REQ_W +: ALIGN_W];
    end
  end

  // Step datapath.
  pra_step #(
    .FRAMES (FRAMES)
  ) u_step (
    .kind          (in_kind_r),
    .request_bytes (in_req_r),
    .align_log2    (in_align_r),
    .ring_ready    (ring_ready_r),
    .base_address  (base_address_r),
    .slice_pages   (slice_pages_r),
    .ctx           (ctx_r),
    .frame_idx     (frame_idx_r),
    .ctx_nxt       (ctx_nxt),
    .frame_idx_nxt (frame_idx_nxt),
    .res           (res_nxt)
  );

  // Allocator state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= '0;
      frame_idx_r <= '0;
    end else if (advance) begin
      ctx_r       <= ctx_nxt;
      frame_idx_r <= frame_idx_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

  // Assertions.
  a_frame_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_idx_r <= LAST_FRAME)
    else $error("frame index beyond the last slice");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.offset <= MAX_SLICE_BYTES)
    else $error("slice offset beyond the largest slice");

  a_refused_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.granted) |-> (out_res_r.address == '0))
    else $error("refused beat carries an address");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.peak >= $past(ctx_r.peak))
    else $error("high-water mark decreased");

endmodule

// ===== verif/per_frame_ring_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-frame ring allocator testbench
// Sends allocate, begin-frame, restart and unused-kind beats through the
// allocator under a series of register settings. A behavioral copy of the
// slice bookkeeping predicts every result beat, and each field is checked.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module per_frame_ring_allocator_test;
  import pra_pkg::*;

  localparam int FRAMES = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WAIT = 17;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 94;
  localparam int MAX_PRINTED = 40;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [REQ_W-1:0]   req;
    logic [ALIGN_W-1:0] align;
  } request_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies and allocator state of the predictor.
  logic                ring_on = 1'b0;
  logic [ADDR_W-1:0]   addr_base = '0;
  logic [PAGES_W-1:0]  ring_pages = '0;
  logic [OFF_W-1:0]    slice_off = '0;
  logic [2:0]          cur_frame = '0;
  logic [OFF_W-1:0]    peak_use = '0;
  logic                ovf_seen = 1'b0;

  request_t pending_beats[$];
  res_t     expected_results[$];

  int sent_beats = 0;
  int taken_beats = 0;
  int results_seen = 0;
  int results_paced = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int errors = 0;
  int cycles = 0;
  int reg_writes = 0;
  int n_grants = 0;
  int n_refused = 0;
  int n_frames = 0;
  int n_restarts = 0;
  int n_ignored = 0;

  per_frame_ring_allocator #(
    .FRAMES(FRAMES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Slice size in bytes, with the page count saturated at the ring maximum.
  function automatic longint unsigned slice_bytes();
    logic [PAGES_W-1:0] pages;
    pages = (ring_pages > MAX_SLICE_PAGES) ? MAX_SLICE_PAGES : ring_pages;
    return 64'(pages) << PAGE_SHIFT;
  endfunction

  // Apply one beat to the slice bookkeeping and return the result it gives.
  function automatic res_t step_allocator(logic [KIND_W-1:0] kind,
                                          logic [REQ_W-1:0] req,
                                          logic [ALIGN_W-1:0] lg);
    longint unsigned slice, align, aligned;
    res_t r;
    r = '0;
    slice = slice_bytes();
    case (kind)
      KIND_ALLOC: begin
        if (ring_on) begin
          align = 64'd1 << lg;
          aligned = (64'(slice_off) + align - 1) & ~(align - 1);
          if (aligned + 64'(req) > slice) begin
            ovf_seen = 1'b1;
            n_refused++;
          end else begin
            slice_off = OFF_W'(aligned + 64'(req));
            r.granted = 1'b1;
            r.address = ADDR_W'(64'(addr_base) + 64'(cur_frame) * slice + aligned);
            n_grants++;
          end
        end else begin
          // A ring that is not ready refuses without touching the flag.
          n_refused++;
        end
      end
      KIND_FRAME: begin
        if (slice_off > peak_use) peak_use = slice_off;
        cur_frame = 3'((32'(cur_frame) + 1) % FRAMES);
        slice_off = '0;
        ovf_seen = 1'b0;
        n_frames++;
      end
      KIND_RESTART: begin
        // Peak and overflow survive a restart.
        slice_off = '0;
        cur_frame = '0;
        n_restarts++;
      end
      default: begin
        n_ignored++;
      end
    endcase
    r.high_water = peak_use;
    r.overflowed = ovf_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got_v,
                                 longint unsigned want_v);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got_v, want_v);
  endtask

  function automatic int draw_wait(bit idle);
    return idle ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Check result beats, then predict from the input beat taken at this edge.
  always @(posedge clk) begin
    res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = out_tdata[$bits(res_t)-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", got, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.granted !== want.granted)
            report_mismatch("granted", got.granted, want.granted);
          if (got.address !== want.address)
            report_mismatch("address", got.address, want.address);
          if (got.high_water !== want.high_water)
            report_mismatch("high_water", got.high_water, want.high_water);
          if (got.overflowed !== want.overflowed)
            report_mismatch("overflowed", got.overflowed, want.overflowed);
        end
      end
      if (in_tvalid && in_tready) begin
        taken_beats++;
        expected_results.push_back(step_allocator(in_tuser, in_tdata[REQ_W-1:0],
                                                  in_tdata[REQ_W +: ALIGN_W]));
      end
    end
  end

  // Input driver: holds a beat until it is taken, then idles or loads the next.
  always @(negedge clk) begin
    request_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && taken_beats != sent_beats)) begin
      if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait--;
      end else if (pending_beats.size() != 0) begin
        beat = pending_beats.pop_front();
        in_tuser <= beat.kind;
        in_tdata <= IN_DATA_W'({beat.align, beat.req});
        in_tvalid <= 1'b1;
        sent_beats++;
        send_wait = draw_wait(send_idle);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result beat, stalls for a drawn number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (results_seen != results_paced) begin
      results_paced = results_seen;
      recv_wait = draw_wait(recv_idle);
      out_tready <= (recv_wait == 0);
      if (recv_wait > 0) recv_wait--;
    end else if (recv_wait > 0) begin
      out_tready <= 1'b0;
      recv_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RING_READY:   ring_on = val[0];
      CFG_BASE_ADDRESS: addr_base = val[ADDR_W-1:0];
      CFG_SLICE_PAGES:  ring_pages = val[PAGES_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void queue_beat(logic [KIND_W-1:0] kind, logic [REQ_W-1:0] req,
                                     logic [ALIGN_W-1:0] align);
    request_t b;
    b.kind = kind;
    b.req = req;
    b.align = align;
    pending_beats.push_back(b);
  endfunction

  // Sender holds off until every beat is taken and every result is back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || taken_beats != sent_beats ||
           expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly allocations sized to the slice, with frame turns frequent enough
  // that the overflow flag keeps clearing; the rest is noise.
  function automatic request_t random_beat();
    request_t b;
    int sel;
    longint unsigned slice;
    slice = slice_bytes();
    sel = $urandom_range(0, 99);
    b.kind = KIND_ALLOC;
    b.req = REQ_W'($urandom_range(0, 32'(slice / 3) + 64));
    b.align = ALIGN_W'($urandom_range(0, 12));
    if (sel >= 62 && sel < 70) begin
      b.req = REQ_W'($urandom);
      b.align = ALIGN_W'($urandom);
    end else if (sel >= 70 && sel < 74) begin
      b.align = ALIGN_W'($urandom_range(13, 15));
    end else if (sel >= 74 && sel < 88) begin
      b.kind = KIND_FRAME;
      b.req = REQ_W'($urandom);
      b.align = ALIGN_W'($urandom);
    end else if (sel >= 88 && sel < 95) begin
      b.kind = KIND_RESTART;
      b.req = REQ_W'($urandom);
      b.align = ALIGN_W'($urandom);
    end else if (sel >= 95 && sel < 97) begin
      b.kind = KIND_UNUSED;
      b.req = REQ_W'($urandom);
      b.align = ALIGN_W'($urandom);
    end else if (sel >= 97) begin
      // Exact fit of a whole slice.
      b.req = REQ_W'(slice);
    end
    return b;
  endfunction

  initial begin
    int sel;
    logic [CFG_DATA_W-1:0] pages_val, base_val;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    recv_idle = 1'b1;

    // Registers still at reset: the ring is not ready.
    queue_beat(KIND_ALLOC, 25'd16, 4'd0);
    queue_beat(KIND_UNUSED, 25'h1FFFFFF, 4'd15);
    wait_idle();

    // One-page slices near the top of the address space, so grants wrap.
    write_reg(CFG_RING_READY, 32'd1);
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_F000);
    write_reg(CFG_SLICE_PAGES, 32'd1);
    @(posedge clk);
    queue_beat(KIND_ALLOC, 25'd0, 4'd0);
    queue_beat(KIND_ALLOC, 25'd100, 4'd0);
    queue_beat(KIND_ALLOC, 25'd1, 4'd12);
    queue_beat(KIND_ALLOC, 25'd0, 4'd12);
    queue_beat(KIND_ALLOC, 25'd0, 4'd15);
    queue_beat(KIND_UNUSED, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    queue_beat(KIND_ALLOC, 25'd4096, 4'd0);
    queue_beat(KIND_RESTART, 25'd0, 4'd0);
    queue_beat(KIND_ALLOC, 25'h1FFFFFF, 4'd15);
    queue_beat(KIND_RESTART, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    wait_idle();

    // Oversized page count saturates to the largest slice.
    send_idle = 1'b1;
    write_reg(CFG_SLICE_PAGES, 32'd8191);
    write_reg(CFG_BASE_ADDRESS, 32'd0);
    @(posedge clk);
    queue_beat(KIND_ALLOC, 25'd16777216, 4'd0);
    queue_beat(KIND_ALLOC, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    queue_beat(KIND_ALLOC, 25'd16777216, 4'd3);
    wait_idle();

    // Slice shrunk below the current offset in the middle of a frame.
    write_reg(CFG_SLICE_PAGES, 32'd1);
    @(posedge clk);
    queue_beat(KIND_ALLOC, 25'd0, 4'd0);
    queue_beat(KIND_FRAME, 25'd0, 4'd0);
    queue_beat(KIND_ALLOC, 25'd4096, 4'd0);
    wait_idle();

    // Ring taken away again; the unused register index changes nothing.
    write_reg(CFG_RING_READY, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    @(posedge clk);
    queue_beat(KIND_ALLOC, 25'd0, 4'd0);
    wait_idle();

    // Random phases, each under its own register setting and idling pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: pages_val = 32'd0;
        1: pages_val = 32'd1;
        2: pages_val = $urandom_range(2, 16);
        3: pages_val = 32'd4096;
        4: pages_val = $urandom_range(4097, 8191);
        default: pages_val = $urandom_range(0, 8191);
      endcase
      sel = $urandom_range(0, 3);
      base_val = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
      if (p == 0) pages_val = 32'd4096;
      write_reg(CFG_RING_READY, ($urandom_range(0, 7) != 0 || p == 0) ? 32'd1 : 32'd0);
      write_reg(CFG_BASE_ADDRESS, base_val);
      write_reg(CFG_SLICE_PAGES, pages_val);
      send_idle = p[0];
      recv_idle = p[1];
      @(posedge clk);
      for (int i = 0; i < BEATS_PER_PHASE; i++)
        pending_beats.push_back(random_beat());
      wait_idle();
    end

    $display("Covered %0d beats over %0d register writes: %0d grants, %0d refusals,",
             taken_beats, reg_writes, n_grants, n_refused);
    $display("%0d frame turns, %0d restarts, %0d unused-kind beats, %0d mismatches",
             n_frames, n_restarts, n_ignored, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
